@@ sv/assert_macros.svh @@
// Assertion macros shared by the response chainer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ARC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ARC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ARC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ARC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/arc_pkg.sv @@
// Package for the APDU response chainer: widths, command codes, status words,
// the frame descriptor and the store write request. No dependencies.
package arc_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 254;
	localparam int STORE_BYTES_DEF     = 1024;

	localparam int CMD_W   = 2;
	localparam int IDX_W   = 10;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 11;
	localparam int REQ_W   = 8;
	localparam int SIZE_W  = 8;
	localparam int WORD_W  = 32;
	localparam int CNT_W   = 3;
	localparam int SW_W    = 16;
	localparam int NUM_LANES = 4;
	localparam int LANE_W  = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_LOAD  = 2'd0;
	localparam cmd_t CMD_START = 2'd1;
	localparam cmd_t CMD_GET   = 2'd2;

	localparam logic [SW_W-1:0] SW_DONE = 16'h9000;
	localparam logic [SW_W-1:0] SW_MORE = 16'h6100;

	// One frame to emit: store start, data byte count, trailing status word, done flag.
	typedef struct packed {
		logic [LEN_W-1:0]  pos;
		logic [SIZE_W-1:0] size;
		logic [SW_W-1:0]   status;
		logic              done;
	} frame_desc_t;

	// Byte write request from the front end into the store.
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
	} store_wr_t;

endpackage

@@ sv/arc_in_if.sv @@
// Request channel of the response chainer: valid/ready plus item fields.
// Depends on arc_pkg for field widths.
interface arc_in_if;
	logic                       valid;
	logic                       ready;
	logic [arc_pkg::CMD_W-1:0]  cmd;
	logic [arc_pkg::IDX_W-1:0]  byte_index;
	logic [arc_pkg::BYTE_W-1:0] data_byte;
	logic [arc_pkg::LEN_W-1:0]  total_length;
	logic [arc_pkg::REQ_W-1:0]  requested_size;

	modport source (output valid, cmd, byte_index, data_byte, total_length, requested_size,
		input ready);
	modport sink (input valid, cmd, byte_index, data_byte, total_length, requested_size,
		output ready);
endinterface

@@ sv/arc_out_if.sv @@
// Result channel of the response chainer: valid/ready plus one frame word.
// Depends on arc_pkg for field widths.
interface arc_out_if;
	logic                       valid;
	logic                       ready;
	logic [arc_pkg::WORD_W-1:0] out_word;
	logic [arc_pkg::CNT_W-1:0]  byte_count;
	logic                       frame_last;
	logic                       transfer_done;

	modport source (output valid, out_word, byte_count, frame_last, transfer_done,
		input ready);
	modport sink (input valid, out_word, byte_count, frame_last, transfer_done,
		output ready);
endinterface

@@ sv/arc_queue.sv @@
// Short descriptor queue between front end and frame emitter.
// Depends on arc_pkg.
module arc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  arc_pkg::frame_desc_t push_data,
	output logic                 full,
	input  logic                 pop,
	output arc_pkg::frame_desc_t pop_data,
	output logic                 empty
);

	arc_pkg::frame_desc_t            slot_q [arc_pkg::QUEUE_DEPTH];
	logic [arc_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [arc_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [arc_pkg::QCNT_W-1:0]      count_q;

	assign full     = (count_q == arc_pkg::QCNT_W'(arc_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	function automatic logic [arc_pkg::QPTR_W-1:0] next_ptr(
		input logic [arc_pkg::QPTR_W-1:0] p);
		if (p == arc_pkg::QPTR_W'(arc_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/arc_front.sv @@
// Front end: accepts requests, writes loads into the store, plans each frame
// and tracks response length and sent count. Depends on arc_pkg, arc_in_if.
module arc_front #(
	parameter int MAX_FRAME_BYTES = arc_pkg::MAX_FRAME_BYTES_DEF,
	parameter int STORE_BYTES     = arc_pkg::STORE_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	arc_in_if.sink               item,
	input  logic                 q_full,
	input  logic                 pending,
	output logic                 q_push,
	output arc_pkg::frame_desc_t q_data,
	output arc_pkg::store_wr_t   wr
);

	logic [arc_pkg::LEN_W-1:0]  length_q;
	logic [arc_pkg::LEN_W-1:0]  sent_q;

	logic                       is_load, is_start, is_get, acc;
	logic [arc_pkg::LEN_W-1:0]  len_sat, base_len, base_sent, remaining, rem_after;
	logic [arc_pkg::REQ_W-1:0]  req;
	logic [arc_pkg::SIZE_W-1:0] limit, size;
	logic                       has_rem;
	logic [arc_pkg::SW_W-1:0]   status;

	assign is_load  = (item.cmd == arc_pkg::CMD_LOAD);
	assign is_start = (item.cmd == arc_pkg::CMD_START);
	assign is_get   = (item.cmd == arc_pkg::CMD_GET);

	// Hold all requests on a full queue, and loads while frames await store reads.
	assign item.ready = !q_full && (!is_load || !pending);
	assign acc        = item.valid && item.ready;

	always_comb begin
		if (32'(item.total_length) > 32'(STORE_BYTES)) begin
			len_sat = arc_pkg::LEN_W'(STORE_BYTES);
		end else begin
			len_sat = item.total_length;
		end
		base_len  = is_start ? len_sat : length_q;
		base_sent = is_start ? '0 : sent_q;
		if (is_start) begin
			req = (len_sat < arc_pkg::LEN_W'(MAX_FRAME_BYTES)) ?
				arc_pkg::REQ_W'(len_sat) : '0;
		end else begin
			req = item.requested_size;
		end
		if (req == '0 || req > arc_pkg::REQ_W'(MAX_FRAME_BYTES)) begin
			limit = arc_pkg::SIZE_W'(MAX_FRAME_BYTES);
		end else begin
			limit = req;
		end
		has_rem   = base_len > base_sent;
		remaining = base_len - base_sent;
		size      = (remaining < arc_pkg::LEN_W'(limit)) ?
			arc_pkg::SIZE_W'(remaining) : limit;
		rem_after = remaining - arc_pkg::LEN_W'(size);
		if (rem_after == '0) begin
			status = arc_pkg::SW_DONE;
		end else if (rem_after < arc_pkg::LEN_W'(MAX_FRAME_BYTES)) begin
			status = arc_pkg::SW_MORE | {8'h00, rem_after[7:0]};
		end else begin
			status = arc_pkg::SW_MORE;
		end
	end

	assign q_push        = acc && (is_start || is_get) && has_rem;
	assign q_data.pos    = base_sent;
	assign q_data.size   = size;
	assign q_data.status = status;
	assign q_data.done   = (rem_after == '0);

	assign wr.en   = acc && is_load && (32'(item.byte_index) < 32'(STORE_BYTES));
	assign wr.addr = item.byte_index;
	assign wr.data = item.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			sent_q   <= '0;
		end else if (acc && (is_start || is_get)) begin
			length_q <= base_len;
			sent_q   <= has_rem ? base_sent + arc_pkg::LEN_W'(size) : base_sent;
		end
	end

endmodule

@@ sv/arc_back.sv @@
// Frame emitter: owns the four byte-lane store banks, walks each frame
// descriptor and emits packed words. Depends on arc_pkg, arc_out_if.
module arc_back #(
	parameter int STORE_BYTES = arc_pkg::STORE_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  arc_pkg::store_wr_t   wr,
	input  logic                 q_empty,
	input  arc_pkg::frame_desc_t q_data,
	output logic                 q_pop,
	output logic                 busy,
	arc_out_if.source            result
);

	localparam int BANK_DEPTH = (STORE_BYTES + 3) / 4;
	localparam int BAW        = $clog2(BANK_DEPTH);

	// frame walker
	logic                        active_q;
	logic [arc_pkg::LEN_W-1:0]   pos_q;
	logic [arc_pkg::SIZE_W-1:0]  data_left_q;
	logic [1:0]                  stat_left_q;
	logic [arc_pkg::SW_W-1:0]    status_q;
	logic                        done_q;

	// read stage
	logic                        valid_s1;
	logic [arc_pkg::CNT_W-1:0]   cnt_s1, nd_s1;
	logic [arc_pkg::LANE_W-1:0]  rot_s1;
	logic                        stat_hi_s1, last_s1, done_s1;
	logic [arc_pkg::SW_W-1:0]    status_s1;
	logic [arc_pkg::BYTE_W-1:0]  lane_data_s1 [arc_pkg::NUM_LANES];

	// output stage
	logic                        valid_s2;
	logic [arc_pkg::WORD_W-1:0]  word_s2;
	logic [arc_pkg::CNT_W-1:0]   cnt_s2;
	logic                        last_s2, done_s2;

	logic                        ready_s1, ready_s2, issue, last_word;
	logic [arc_pkg::CNT_W-1:0]   nd, ns, room;
	logic [BAW-1:0]              rd_addr [arc_pkg::NUM_LANES];
	logic [BAW-1:0]              wr_addr;
	logic [arc_pkg::WORD_W-1:0]  word_build;

	assign ready_s2 = !valid_s2 || result.ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign issue    = active_q && ready_s1;
	assign q_pop    = !active_q && !q_empty;
	assign busy     = active_q;

	always_comb begin
		nd        = (data_left_q >= arc_pkg::SIZE_W'(4)) ? 3'd4 : data_left_q[2:0];
		room      = 3'd4 - nd;
		ns        = ({1'b0, stat_left_q} < room) ? {1'b0, stat_left_q} : room;
		last_word = (data_left_q == arc_pkg::SIZE_W'(nd)) && ({1'b0, stat_left_q} == ns);
	end

	// Each lane reads the next store byte that falls in it from the current position.
	always_comb begin
		for (int b = 0; b < arc_pkg::NUM_LANES; b++) begin
			rd_addr[b] = BAW'(({1'b0, pos_q} +
				{{(arc_pkg::LEN_W - 1){1'b0}}, 2'(2'(b) - pos_q[1:0])}) >> 2);
		end
	end

	assign wr_addr = BAW'(wr.addr >> 2);

	for (genvar b = 0; b < arc_pkg::NUM_LANES; b++) begin : g_lane
		logic [arc_pkg::BYTE_W-1:0] bank_mem [BANK_DEPTH];
		always_ff @(posedge clk) begin
			if (wr.en && wr.addr[1:0] == 2'(b)) begin
				bank_mem[wr_addr] <= wr.data;
			end
			if (issue) begin
				lane_data_s1[b] <= bank_mem[rd_addr[b]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (q_pop) begin
			active_q <= 1'b1;
		end else if (issue && last_word) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pos_q       <= q_data.pos;
			data_left_q <= q_data.size;
			stat_left_q <= 2'd2;
			status_q    <= q_data.status;
			done_q      <= q_data.done;
		end else if (issue) begin
			pos_q       <= pos_q + arc_pkg::LEN_W'(nd);
			data_left_q <= data_left_q - arc_pkg::SIZE_W'(nd);
			stat_left_q <= stat_left_q - ns[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cnt_s1     <= nd + ns;
			nd_s1      <= nd;
			rot_s1     <= pos_q[1:0];
			stat_hi_s1 <= (stat_left_q == 2'd2);
			status_s1  <= status_q;
			last_s1    <= last_word;
			done_s1    <= last_word && done_q;
		end
	end

	// Data bytes first, then the status bytes, zero past the count.
	always_comb begin
		word_build = '0;
		for (int k = 0; k < arc_pkg::NUM_LANES; k++) begin
			if (3'(k) < nd_s1) begin
				word_build[arc_pkg::WORD_W - 1 - 8*k -: 8] = lane_data_s1[2'(rot_s1 + 2'(k))];
			end else if (3'(k) < cnt_s1) begin
				word_build[arc_pkg::WORD_W - 1 - 8*k -: 8] =
					(3'(k) == nd_s1 && stat_hi_s1) ? status_s1[15:8] : status_s1[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			word_s2 <= word_build;
			cnt_s2  <= cnt_s1;
			last_s2 <= last_s1;
			done_s2 <= done_s1;
		end
	end

	assign result.valid         = valid_s2;
	assign result.out_word      = word_s2;
	assign result.byte_count    = cnt_s2;
	assign result.frame_last    = last_s2;
	assign result.transfer_done = done_s2;

endmodule

@@ sv/apdu_response_chainer_core.sv @@
// Top level of the APDU response chainer: front end, descriptor queue and
// frame emitter. Depends on arc_pkg, arc_in_if, arc_out_if, assert_macros.svh.
//
//   channel   dir   modport  request carries
//   item      in    sink     cmd, byte_index, data_byte, total_length, requested_size
//   result    out   source   out_word, byte_count, frame_last, transfer_done
//
// A start or get-response request is planned in the cycle it is accepted and
// queued; the emitter then sends the ceil((size + 2) / 4) words of the frame at one word
// per cycle while the result channel is ready, at most 64 words for a full frame,
// limited by the four one-byte store lanes; the walker pauses to pop each new descriptor.
// Load requests stall until the emitter has read every queued frame.
// Reset clears length, sent count, queue and pipeline valids; store is undefined.
// Output stalls hold two words in flight while the queue takes requests until full.
`include "assert_macros.svh"

module apdu_response_chainer_core #(
	parameter int MAX_FRAME_BYTES = arc_pkg::MAX_FRAME_BYTES_DEF,
	parameter int STORE_BYTES     = arc_pkg::STORE_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	arc_in_if.sink    item,
	arc_out_if.source result
);

	arc_pkg::frame_desc_t push_data, pop_data;
	arc_pkg::store_wr_t   wr;
	logic                 q_push, q_pop, q_full, q_empty, busy, pending;

	// Frames still waiting on store reads block byte loads.
	assign pending = busy || !q_empty;

	arc_front #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES),
		.STORE_BYTES     (STORE_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.q_full  (q_full),
		.pending (pending),
		.q_push  (q_push),
		.q_data  (push_data),
		.wr      (wr)
	);

	arc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	arc_back #(
		.STORE_BYTES (STORE_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.q_empty (q_empty),
		.q_data  (pop_data),
		.q_pop   (q_pop),
		.busy    (busy),
		.result  (result)
	);

	// Never push into a full queue.
	`ARC_ASSERT_IMPLIES(a_queue_no_overflow, clk, arst_n, q_push, !q_full)
	// A store write never races a frame still being read.
	`ARC_ASSERT_IMPLIES(a_load_after_drain, clk, arst_n, wr.en, !busy && q_empty)
	// A popped descriptor starts the walker.
	`ARC_ASSERT_NEXT(a_pop_starts_walk, clk, arst_n, q_pop, busy)
	// Completion marks only the closing word of a frame.
	`ARC_ASSERT_IMPLIES(a_done_on_last, clk, arst_n, result.valid && result.transfer_done, result.frame_last)

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for apdu_response_chainer_core: request table plus random chains,
// checked word by word against a frame predictor kept inside this file.
// Depends on arc_pkg, arc_in_if and arc_out_if from the RTL.
module tb_top;
	import arc_pkg::*;

	localparam int MAX_FRAME    = MAX_FRAME_BYTES_DEF;
	localparam int STORE        = STORE_BYTES_DEF;
	localparam int RAND_ITEMS   = 160;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int TAIL_CYCLES  = 20;
	localparam int PRINT_LIMIT  = 20;
	// Typed-in word count of a table row; this value defers to the predictor.
	localparam int FROM_MODEL   = -1;
	// The package leaves the fourth command code unnamed; the block ignores it.
	localparam cmd_t CMD_UNUSED = 2'd3;

	// One request plus, for table rows, an optional typed-in single-word answer.
	typedef struct {
		cmd_t              cmd;
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] dat;
		logic [LEN_W-1:0]  len;
		logic [REQ_W-1:0]  req;
		int                exp_n;
		logic [WORD_W-1:0] exp_word;
		logic [CNT_W-1:0]  exp_cnt;
		logic              exp_done;
	} stim_row_t;

	// One word of a frame as it should leave the result channel.
	typedef struct {
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  cnt;
		logic              last;
		logic              done;
	} frame_word_t;

	logic clk;
	logic arst_n;

	arc_in_if  item_bus ();
	arc_out_if result_bus ();

	apdu_response_chainer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	// Predictor state: shadow of the response store, length and bytes already sent.
	logic [BYTE_W-1:0] shadow_store [STORE];
	logic [LEN_W-1:0]  resp_len;
	logic [LEN_W-1:0]  sent_cnt;

	frame_word_t planned_words [$];   // words of the frame planned by the last request
	frame_word_t pending_words [$];   // words still owed by the block, oldest first

	stim_row_t directed [$];

	int sender_idle_pct;
	int receiver_stall_pct;
	bit hold_off_req;

	int n_items;
	int n_ignored;
	int n_words;
	int n_frames;
	int n_transfers;
	int errors;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run guard: far beyond the slowest correct run, full-size frames included.
	initial begin
		#(50_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Plan one frame of the current response: data bytes, status word, four
	// bytes per word. Advance the sent count past the data bytes.
	task automatic plan_frame(input int unsigned req);
		int unsigned remaining, limit, size, total, n, i, k;
		logic [SW_W-1:0] status;
		logic [BYTE_W-1:0] frame_bytes [$];
		frame_word_t fw;
		if (resp_len <= sent_cnt)
			return;
		remaining = resp_len - sent_cnt;
		// Zero asks for the largest frame; anything above it is clamped.
		limit = (req == 0 || req > MAX_FRAME) ? MAX_FRAME : req;
		size = (remaining < limit) ? remaining : limit;
		remaining -= size;
		// 61xx reports the rest only when it fits below a full frame.
		if (remaining == 0)
			status = SW_DONE;
		else if (remaining < MAX_FRAME)
			status = SW_MORE | SW_W'(remaining & 'h00ff);
		else
			status = SW_MORE;
		for (i = 0; i < size; i++)
			frame_bytes.push_back(shadow_store[sent_cnt + i]);
		frame_bytes.push_back(status[15:8]);
		frame_bytes.push_back(status[7:0]);
		total = size + 2;
		for (i = 0; i < total; i += 4) begin
			n = (total - i > 4) ? 4 : total - i;
			fw.word = '0;
			for (k = 0; k < n; k++)
				fw.word[31 - 8 * k -: 8] = frame_bytes[i + k];
			fw.cnt = CNT_W'(n);
			fw.last = (i + n) >= total;
			fw.done = fw.last && remaining == 0;
			planned_words.push_back(fw);
		end
		sent_cnt = sent_cnt + LEN_W'(size);
	endtask

	// Apply one accepted request to the predictor; the frame lands in planned_words.
	task automatic apply_request(input stim_row_t r);
		int unsigned len;
		planned_words.delete();
		case (r.cmd)
			CMD_LOAD: begin
				// Indexes past the store end are dropped (none exist at this size).
				if (r.idx < STORE)
					shadow_store[r.idx] = r.dat;
			end
			CMD_START: begin
				// Saturate the length to the store and send the first frame at full size.
				len = (r.len > STORE) ? STORE : r.len;
				resp_len = LEN_W'(len);
				sent_cnt = '0;
				plan_frame((len < MAX_FRAME) ? len : 0);
			end
			CMD_GET: plan_frame(r.req);
			default: ;
		endcase
	endtask

	function automatic stim_row_t row(cmd_t c, int idx, int dat, int len, int req,
			int exp_n, logic [WORD_W-1:0] exp_word, int exp_cnt, logic exp_done);
		stim_row_t r;
		r.cmd = c;
		r.idx = IDX_W'(idx);
		r.dat = BYTE_W'(dat);
		r.len = LEN_W'(len);
		r.req = REQ_W'(req);
		r.exp_n = exp_n;
		r.exp_word = exp_word;
		r.exp_cnt = CNT_W'(exp_cnt);
		r.exp_done = exp_done;
		return r;
	endfunction

	// Random content in every field; callers pin down the fields that matter.
	function automatic stim_row_t noise_row(cmd_t c);
		return row(c, $urandom_range(0, STORE - 1), $urandom_range(0, 255),
			$urandom_range(0, 2047), $urandom_range(0, 255), FROM_MODEL, '0, 0, 1'b0);
	endfunction

	function automatic void set_phase(int p);
		case (p)
			0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
			1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
			2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
			default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
		endcase
	endfunction

	// Offer one request: random idle gap first, drive at the falling edge, hold
	// until accepted, then record the words it owes.
	task automatic issue_request(input stim_row_t r);
		frame_word_t fw;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			@(negedge clk);
			item_bus.valid <= 1'b0;
		end
		@(negedge clk);
		item_bus.valid          <= 1'b1;
		item_bus.cmd            <= r.cmd;
		item_bus.byte_index     <= r.idx;
		item_bus.data_byte      <= r.dat;
		item_bus.total_length   <= r.len;
		item_bus.requested_size <= r.req;
		forever begin
			@(posedge clk);
			if (item_bus.ready)
				break;
		end
		apply_request(r);
		if (r.exp_n == FROM_MODEL) begin
			foreach (planned_words[i])
				pending_words.push_back(planned_words[i]);
		end else if (r.exp_n == 1) begin
			fw.word = r.exp_word;
			fw.cnt = r.exp_cnt;
			fw.last = 1'b1;
			fw.done = r.exp_done;
			pending_words.push_back(fw);
		end
		if (r.cmd == CMD_UNUSED)
			n_ignored++;
		else
			n_items++;
	endtask

	// Well-formed chain with random content: up to four loads, a start, then a run of
	// get-response requests. Some chains stop early, some poll past the end.
	task automatic run_chain();
		int n_loads, n_gets, pick, i;
		stim_row_t r;
		n_loads = $urandom_range(0, 4);
		for (i = 0; i < n_loads; i++)
			issue_request(noise_row(CMD_LOAD));
		r = noise_row(CMD_START);
		pick = $urandom_range(0, 99);
		if (pick < 30)
			r.len = LEN_W'($urandom_range(1, MAX_FRAME - 1));
		else if (pick < 88)
			r.len = LEN_W'($urandom_range(MAX_FRAME + 1, 420));
		else if (pick < 94)
			r.len = LEN_W'(MAX_FRAME);
		else
			r.len = LEN_W'($urandom_range(STORE, 2047));
		issue_request(r);
		n_gets = $urandom_range(1, 6);
		for (i = 0; i < n_gets; i++) begin
			if (sent_cnt >= resp_len && $urandom_range(0, 3) != 0)
				break;
			r = noise_row(CMD_GET);
			pick = $urandom_range(0, 99);
			// Keep most frames short; only a few ask for the largest size.
			if (pick < 80)
				r.req = REQ_W'($urandom_range(1, 32));
			else if (pick < 88)
				r.req = '0;
			else if (pick < 94)
				r.req = 8'hff;
			else
				r.req = REQ_W'($urandom_range(128, MAX_FRAME));
			issue_request(r);
		end
	endtask

	// Receiver: random stalls per phase. On request, hold ready low for a long
	// stretch so the queue fills and the block pushes back on its input.
	initial begin
		result_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			result_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// Checker: every accepted word must match the oldest word still owed.
	always @(posedge clk) begin
		frame_word_t fw;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			n_words++;
			if (result_bus.frame_last === 1'b1)
				n_frames++;
			if (result_bus.transfer_done === 1'b1)
				n_transfers++;
			if (pending_words.size() == 0) begin
				errors++;
				if (errors <= PRINT_LIMIT)
					$display("%0t: unexpected word: got word=%h cnt=%0d last=%b done=%b",
						$time, result_bus.out_word, result_bus.byte_count,
						result_bus.frame_last, result_bus.transfer_done);
			end else begin
				fw = pending_words.pop_front();
				if (result_bus.out_word !== fw.word || result_bus.byte_count !== fw.cnt ||
						result_bus.frame_last !== fw.last ||
						result_bus.transfer_done !== fw.done) begin
					errors++;
					if (errors <= PRINT_LIMIT)
						$display({"%0t: word mismatch: expected word=%h cnt=%0d last=%b",
							" done=%b, got word=%h cnt=%0d last=%b done=%b"},
							$time, fw.word, fw.cnt, fw.last, fw.done,
							result_bus.out_word, result_bus.byte_count,
							result_bus.frame_last, result_bus.transfer_done);
				end
			end
		end
	end

	// Main sequence: reset, fill the store, walk the table, then random chains.
	initial begin
		int base, drain_cycles, pick;
		bit pressure_done;
		stim_row_t r;

		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.cmd = CMD_LOAD;
		item_bus.byte_index = '0;
		item_bus.data_byte = '0;
		item_bus.total_length = '0;
		item_bus.requested_size = '0;
		hold_off_req = 1'b0;
		pressure_done = 1'b0;
		resp_len = '0;
		sent_cnt = '0;
		n_items = 0;
		n_ignored = 0;
		n_words = 0;
		n_frames = 0;
		n_transfers = 0;
		errors = 0;
		set_phase(0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Write every store entry once so no frame ever reads an unwritten byte,
		// including the saturated full-store response below.
		for (int i = 0; i < STORE; i++)
			issue_request(row(CMD_LOAD, i, $urandom_range(0, 255), 0, 0, 0, '0, 0, 1'b0));

		//            cmd         idx   dat    len   req  words  word          cnt done
		// Nothing to send yet after reset, unused command, empty response.
		directed.push_back(row(CMD_GET,    0,    8'h00, 0,    0,   0, '0,           0, 1'b0));
		directed.push_back(row(CMD_UNUSED, 1023, 8'hff, 2047, 255, 0, '0,           0, 1'b0));
		directed.push_back(row(CMD_START,  0,    8'h00, 0,    0,   0, '0,           0, 1'b0));
		// Loads emit nothing; cover both index ends and both data extremes.
		directed.push_back(row(CMD_LOAD,   0,    8'haa, 0,    0,   0, '0,           0, 1'b0));
		directed.push_back(row(CMD_LOAD,   1,    8'h55, 0,    0,   0, '0,           0, 1'b0));
		directed.push_back(row(CMD_LOAD,   1023, 8'hff, 0,    0,   0, '0,           0, 1'b0));
		directed.push_back(row(CMD_LOAD,   1022, 8'h00, 0,    0,   0, '0,           0, 1'b0));
		// One-word frames: data then 9000, then a poll once everything is sent.
		directed.push_back(row(CMD_START,  0,    8'h00, 1,    0,   1, 32'haa900000, 3, 1'b1));
		directed.push_back(row(CMD_GET,    0,    8'h00, 0,    0,   0, '0,           0, 1'b0));
		directed.push_back(row(CMD_START,  0,    8'h00, 2,    0,   1, 32'haa559000, 4, 1'b1));
		// Frame sizes around the maximum, and a one-byte tail.
		directed.push_back(row(CMD_START,  0,    8'h00, 3,    0,   FROM_MODEL, '0,  0, 1'b0));
		directed.push_back(row(CMD_START,  0,    8'h00, 253,  0,   FROM_MODEL, '0,  0, 1'b0));
		directed.push_back(row(CMD_START,  0,    8'h00, 254,  0,   FROM_MODEL, '0,  0, 1'b0));
		directed.push_back(row(CMD_START,  0,    8'h00, 255,  0,   FROM_MODEL, '0,  0, 1'b0));
		directed.push_back(row(CMD_GET,    0,    8'h00, 0,    0,   FROM_MODEL, '0,  0, 1'b0));
		// Full store: clamped request, exactly a full frame left (6100), then 61FD.
		directed.push_back(row(CMD_START,  0,    8'h00, 1024, 0,   FROM_MODEL, '0,  0, 1'b0));
		directed.push_back(row(CMD_GET,    0,    8'h00, 0,    255, FROM_MODEL, '0,  0, 1'b0));
		directed.push_back(row(CMD_GET,    0,    8'h00, 0,    254, FROM_MODEL, '0,  0, 1'b0));
		directed.push_back(row(CMD_GET,    0,    8'h00, 0,    8,   FROM_MODEL, '0,  0, 1'b0));
		directed.push_back(row(CMD_GET,    0,    8'h00, 0,    1,   FROM_MODEL, '0,  0, 1'b0));
		directed.push_back(row(CMD_GET,    0,    8'h00, 0,    0,   FROM_MODEL, '0,  0, 1'b0));
		// Length past the store end saturates.
		directed.push_back(row(CMD_START,  0,    8'h00, 2047, 0,   FROM_MODEL, '0,  0, 1'b0));
		directed.push_back(row(CMD_GET,    0,    8'h00, 0,    128, FROM_MODEL, '0,  0, 1'b0));

		foreach (directed[i])
			issue_request(directed[i]);

		// Random part: mostly well-formed chains, the rest stray requests.
		// Advance the idle phase every 40 requests.
		base = n_items;
		while (n_items - base < RAND_ITEMS) begin
			set_phase(((n_items - base) / 40) % 4);
			if (!pressure_done && n_items - base >= 90) begin
				// Long receiver hold-off while the sender keeps offering a chain.
				pressure_done = 1'b1;
				hold_off_req = 1'b1;
				sender_idle_pct = 0;
				run_chain();
			end else if ($urandom_range(0, 99) < 70) begin
				run_chain();
			end else begin
				pick = $urandom_range(0, 3);
				case (pick)
					0: r = noise_row(CMD_LOAD);
					1: r = noise_row(CMD_GET);
					2: r = noise_row(CMD_UNUSED);
					default: begin
						r = noise_row(CMD_START);
						r.len = '0;
					end
				endcase
				issue_request(r);
			end
		end

		@(negedge clk);
		item_bus.valid <= 1'b0;

		// Drain owed words, then give stray words time to show up.
		drain_cycles = 0;
		while (pending_words.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_words.size() != 0) begin
			errors++;
			$display("%0t: %0d expected words never arrived", $time, pending_words.size());
		end

		$display("Sent %0d requests plus %0d with the unused command (store fill included).",
			n_items, n_ignored);
		$display("Checked %0d words in %0d frames, %0d transfers completed, %0d errors.",
			n_words, n_frames, n_transfers, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
